FILE: sv/kesd_pkg.sv
// Package for the key escape sequence decoder.
// Holds the byte codes, parser state codes, key class codes and the
// result struct. It has no dependencies.
package kesd_pkg;

  // Byte codes that the parser matches.
  localparam logic [7:0] BYTE_ESC    = 8'h1B;
  localparam logic [7:0] BYTE_SS3    = 8'h4F;  // 'O'
  localparam logic [7:0] BYTE_CSI    = 8'h5B;  // '['
  localparam logic [7:0] BYTE_LOW_A  = 8'h61;
  localparam logic [7:0] BYTE_LOW_Z  = 8'h7A;
  localparam logic [7:0] BYTE_CASE   = 8'h20;
  localparam logic [7:0] BYTE_CTRL   = 8'h40;
  localparam logic [7:0] BYTE_CTRL_A = 8'h01;
  localparam logic [7:0] BYTE_CTRL_Z = 8'h1A;
  localparam logic [7:0] BYTE_BS     = 8'h08;
  localparam logic [7:0] BYTE_TAB    = 8'h09;
  localparam logic [7:0] BYTE_LF     = 8'h0A;
  localparam logic [7:0] BYTE_CR     = 8'h0D;
  localparam logic [7:0] BYTE_TILDE  = 8'h7E;
  localparam logic [7:0] BYTE_Q      = 8'h51;
  localparam logic [7:0] BYTE_R      = 8'h52;
  localparam logic [7:0] BYTE_S      = 8'h53;
  localparam logic [7:0] BYTE_H      = 8'h48;
  localparam logic [7:0] BYTE_F      = 8'h46;
  localparam logic [7:0] BYTE_A      = 8'h41;
  localparam logic [7:0] BYTE_B      = 8'h42;
  localparam logic [7:0] BYTE_C      = 8'h43;
  localparam logic [7:0] BYTE_D      = 8'h44;
  localparam logic [7:0] DIGIT_0     = 8'h30;
  localparam logic [7:0] DIGIT_1     = 8'h31;
  localparam logic [7:0] DIGIT_2     = 8'h32;
  localparam logic [7:0] DIGIT_4     = 8'h34;
  localparam logic [7:0] DIGIT_5     = 8'h35;
  localparam logic [7:0] DIGIT_6     = 8'h36;
  localparam logic [7:0] DIGIT_7     = 8'h37;
  localparam logic [7:0] DIGIT_8     = 8'h38;
  localparam logic [7:0] DIGIT_9     = 8'h39;

  // Parser states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ESC  = 3'd1;
  localparam logic [2:0] ST_SS3  = 3'd2;
  localparam logic [2:0] ST_CSI  = 3'd3;
  localparam logic [2:0] ST_CSI1 = 3'd4;
  localparam logic [2:0] ST_CSI2 = 3'd5;

  // Key classes.
  localparam logic [2:0] CL_PLAIN   = 3'd0;
  localparam logic [2:0] CL_CTRL    = 3'd1;
  localparam logic [2:0] CL_ALT     = 3'd2;
  localparam logic [2:0] CL_CTRLALT = 3'd3;
  localparam logic [2:0] CL_EDIT    = 3'd4;
  localparam logic [2:0] CL_FUNC    = 3'd5;

  // Decoded key from the parser to the output register.
  typedef struct packed {
    logic       emit;
    logic [2:0] key_class;
    logic [7:0] key_value;
  } key_result_t;

endpackage

FILE: sv/kesd_in_reg.sv
// Input register of the key escape sequence decoder.
// Holds one received word until the parser takes it. Uses kesd_pkg only
// through the parent; no package items are needed here.
module kesd_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  logic held_valid_next;

  // Accept a new word when empty or when the held word leaves this cycle.
  assign in_ready = !held_valid || take;

  always_comb begin
    held_valid_next = held_valid;
    if (in_valid && in_ready) begin
      held_valid_next = 1'b1;
    end else if (take) begin
      held_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= rx_byte;
    end
  end

endmodule

FILE: sv/kesd_parser.sv
// Sequence parser of the key escape sequence decoder.
// Holds the parse state and the two parameter bytes, and decodes one word
// per advance. Depends on kesd_pkg.
module kesd_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic [7:0]            byte_in,
  output kesd_pkg::key_result_t result
);

  logic [2:0] parse_state;
  logic [2:0] parse_state_next;
  logic [7:0] first_param_byte;
  logic [7:0] first_param_byte_next;
  logic [7:0] second_param_byte;
  logic [7:0] second_param_byte_next;

  logic is_lower;
  logic is_ctrl;
  logic is_tilde;

  assign is_lower = (byte_in >= kesd_pkg::BYTE_LOW_A) && (byte_in <= kesd_pkg::BYTE_LOW_Z);
  assign is_ctrl  = (byte_in >= kesd_pkg::BYTE_CTRL_A) && (byte_in <= kesd_pkg::BYTE_CTRL_Z);
  assign is_tilde = (byte_in == kesd_pkg::BYTE_TILDE);

  always_comb begin
    parse_state_next       = kesd_pkg::ST_IDLE;
    first_param_byte_next  = first_param_byte;
    second_param_byte_next = second_param_byte;
    // Default: plain ESC, which also ends any unrecognized sequence.
    result.emit      = 1'b1;
    result.key_class = kesd_pkg::CL_PLAIN;
    result.key_value = kesd_pkg::BYTE_ESC;
    case (parse_state)
      kesd_pkg::ST_ESC: begin
        if (byte_in == kesd_pkg::BYTE_SS3) begin
          result.emit      = 1'b0;
          parse_state_next = kesd_pkg::ST_SS3;
        end else if (byte_in == kesd_pkg::BYTE_CSI) begin
          result.emit      = 1'b0;
          parse_state_next = kesd_pkg::ST_CSI;
        end else if (is_lower) begin
          result.key_class = kesd_pkg::CL_ALT;
          result.key_value = byte_in - kesd_pkg::BYTE_CASE;
        end else if (is_ctrl) begin
          result.key_class = kesd_pkg::CL_CTRLALT;
          result.key_value = byte_in + kesd_pkg::BYTE_CTRL;
        end
      end
      kesd_pkg::ST_SS3: begin
        case (byte_in)
          kesd_pkg::BYTE_Q: begin
            result.key_class = kesd_pkg::CL_FUNC;
            result.key_value = 8'd1;
          end
          kesd_pkg::BYTE_R: begin
            result.key_class = kesd_pkg::CL_FUNC;
            result.key_value = 8'd2;
          end
          kesd_pkg::BYTE_S: begin
            result.key_class = kesd_pkg::CL_FUNC;
            result.key_value = 8'd3;
          end
          kesd_pkg::BYTE_H: begin
            result.key_class = kesd_pkg::CL_EDIT;
            result.key_value = 8'd4;
          end
          kesd_pkg::BYTE_F: begin
            result.key_class = kesd_pkg::CL_EDIT;
            result.key_value = 8'd3;
          end
          default: begin
          end
        endcase
      end
      kesd_pkg::ST_CSI: begin
        case (byte_in)
          kesd_pkg::BYTE_A: begin
            result.key_class = kesd_pkg::CL_EDIT;
            result.key_value = 8'd6;
          end
          kesd_pkg::BYTE_B: begin
            result.key_class = kesd_pkg::CL_EDIT;
            result.key_value = 8'd8;
          end
          kesd_pkg::BYTE_C: begin
            result.key_class = kesd_pkg::CL_EDIT;
            result.key_value = 8'd7;
          end
          kesd_pkg::BYTE_D: begin
            result.key_class = kesd_pkg::CL_EDIT;
            result.key_value = 8'd5;
          end
          default: begin
            result.emit           = 1'b0;
            first_param_byte_next = byte_in;
            parse_state_next      = kesd_pkg::ST_CSI1;
          end
        endcase
      end
      kesd_pkg::ST_CSI1: begin
        if (!is_tilde) begin
          result.emit            = 1'b0;
          second_param_byte_next = byte_in;
          parse_state_next       = kesd_pkg::ST_CSI2;
        end else if (first_param_byte == kesd_pkg::DIGIT_5) begin
          result.key_class = kesd_pkg::CL_EDIT;
          result.key_value = 8'd1;
        end else if (first_param_byte == kesd_pkg::DIGIT_6) begin
          result.key_class = kesd_pkg::CL_EDIT;
          result.key_value = 8'd2;
        end
      end
      kesd_pkg::ST_CSI2: begin
        if (is_tilde) begin
          if (first_param_byte == kesd_pkg::DIGIT_1) begin
            if (second_param_byte == kesd_pkg::DIGIT_5) begin
              result.key_class = kesd_pkg::CL_FUNC;
              result.key_value = 8'd4;
            end else if (second_param_byte == kesd_pkg::DIGIT_7) begin
              result.key_class = kesd_pkg::CL_FUNC;
              result.key_value = 8'd5;
            end else if (second_param_byte == kesd_pkg::DIGIT_8) begin
              result.key_class = kesd_pkg::CL_FUNC;
              result.key_value = 8'd6;
            end else if (second_param_byte == kesd_pkg::DIGIT_9) begin
              result.key_class = kesd_pkg::CL_FUNC;
              result.key_value = 8'd7;
            end
          end else if (first_param_byte == kesd_pkg::DIGIT_2) begin
            if (second_param_byte == kesd_pkg::DIGIT_0) begin
              result.key_class = kesd_pkg::CL_FUNC;
              result.key_value = 8'd8;
            end else if (second_param_byte == kesd_pkg::DIGIT_1) begin
              result.key_class = kesd_pkg::CL_FUNC;
              result.key_value = 8'd9;
            end else if (second_param_byte == kesd_pkg::DIGIT_4) begin
              result.key_class = kesd_pkg::CL_FUNC;
              result.key_value = 8'd11;
            end
          end
        end
      end
      default: begin
        // Idle, and the unused state codes act as idle.
        if (byte_in == kesd_pkg::BYTE_ESC) begin
          result.emit      = 1'b0;
          parse_state_next = kesd_pkg::ST_ESC;
        end else if (is_ctrl && (byte_in != kesd_pkg::BYTE_BS) &&
                     (byte_in != kesd_pkg::BYTE_TAB) && (byte_in != kesd_pkg::BYTE_LF) &&
                     (byte_in != kesd_pkg::BYTE_CR)) begin
          result.key_class = kesd_pkg::CL_CTRL;
          result.key_value = byte_in + kesd_pkg::BYTE_CTRL;
        end else begin
          result.key_value = byte_in;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state       <= kesd_pkg::ST_IDLE;
      first_param_byte  <= 8'd0;
      second_param_byte <= 8'd0;
    end else if (advance) begin
      parse_state       <= parse_state_next;
      first_param_byte  <= first_param_byte_next;
      second_param_byte <= second_param_byte_next;
    end
  end

endmodule

FILE: sv/kesd_out_reg.sv
// Output register of the key escape sequence decoder.
// Holds one decoded key until the sink takes it. Depends on kesd_pkg.
module kesd_out_reg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  kesd_pkg::key_result_t result,
  output logic                  can_advance,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            key_class,
  output logic [7:0]            key_value
);

  logic load;
  logic out_valid_next;

  // The parser may advance when the slot is free or drains this cycle.
  assign can_advance = !out_valid || out_ready;
  assign load        = advance && result.emit;

  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      key_class <= result.key_class;
      key_value <= result.key_value;
    end
  end

endmodule

FILE: sv/key_escape_sequence_decoder_top.sv
// Key escape sequence decoder: keyboard words in, decoded keys out.
// The word that completes a key is accepted into the input register; the parser
// decodes it combinationally and loads the key into the output register when the
// output slot is free or drains, and the key leaves from there on out_ready.
// Throughput: one word per cycle while the output drains; an output stall holds the parser.
// Reset (rst, synchronous): parser goes idle, parameter bytes clear, both
// registers empty. Depends on kesd_pkg, kesd_in_reg, kesd_parser, kesd_out_reg.
module key_escape_sequence_decoder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] key_class,
  output logic [7:0] key_value
);

  logic                  held_valid;
  logic [7:0]            held_byte;
  logic                  can_advance;
  logic                  advance;
  kesd_pkg::key_result_t result;

  // Advance the parser on a held word whenever the output slot can take a
  // key; words that only extend a sequence advance the same way and drop.
  assign advance = held_valid && can_advance;

  kesd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .take       (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  kesd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .byte_in (held_byte),
    .result  (result)
  );

  kesd_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .result      (result),
    .can_advance (can_advance),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .key_class   (key_class),
    .key_value   (key_value)
  );

endmodule
